// File: sv/ampf_pkg.sv
// ampf_pkg: shared constants and command codes for the pulse firing block
// no dependencies
package ampf_pkg;

  localparam int unsigned TotalPins       = 32;
  localparam int unsigned PinsPerExpander = 16;
  localparam int unsigned ShownPins       = (TotalPins < 32) ? TotalPins : 32;

  localparam int unsigned PinW   = 32;  // width of the pin bitmap
  localparam int unsigned CueW   = 6;   // cue number, counted from 1
  localparam int unsigned CntW   = 6;   // holds a cue count up to 32
  localparam int unsigned IdxW   = 5;   // countdown memory address
  localparam int unsigned TickW  = 16;  // countdown and on-time width
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgW   = 16;  // widest configuration register
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CntW-1:0]  ShownCnt     = CntW'(ShownPins);
  localparam logic [CntW-1:0]  UsableReset  = 6'd32;
  localparam logic [TickW-1:0] OnTimeReset  = 16'd1000;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_TRIGGER    = 3'd1,
    CMD_SET_SPARE  = 3'd2,
    CMD_ARM        = 3'd3,
    CMD_BEGIN_TEST = 3'd4,
    CMD_TEST       = 3'd5,
    CMD_END_TEST   = 3'd6
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_USABLE_CUES = 1'b0,
    REG_ON_TIME     = 1'b1
  } cfg_reg_e;

endpackage

// File: sv/armed_multichannel_pulse_firing.sv
// armed_multichannel_pulse_firing: top level of the multi-channel one-shot firing block
// depends on ampf_pkg; holds the command sequencer and the countdown memory
//
// Each input item is one command (tick, trigger, set spare, arm, begin test, test,
// end test) and yields exactly one result item holding the pin bitmap, the accepted
// flag, the armed flag and the test relay flag as they stand after the command.
// Trigger, set spare, arm, the test commands and unknown codes finish in the cycle
// they are accepted. A tick walks the per-cue countdowns one entry per cycle through
// a single decrement unit fed by a countdown memory with registered read, and then
// hands the result over once the result register is free. Input stall is high
// while a tick walk runs and while the result register is full and stalled.
// Countdowns start at zero after reset through one valid bit per entry; no
// clearing pass is needed.
module armed_multichannel_pulse_firing (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [ampf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ampf_pkg::CfgW-1:0]   cfg_data_i,
  // command items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ampf_pkg::CmdW-1:0]   cmd_i,
  input  logic [ampf_pkg::CueW-1:0]   cue_i,
  input  logic                        level_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ampf_pkg::PinW-1:0]   pin_levels_o,
  output logic                        accepted_o,
  output logic                        armed_o,
  output logic                        test_relay_on_o
);
  import ampf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_OUT
  } state_e;

  // sequencer and block state
  state_e            state_q, state_d;
  logic [CntW-1:0]   usable_q, usable_d;
  logic [TickW-1:0]  on_time_q, on_time_d;
  logic [PinW-1:0]   pin_q, pin_d;
  logic              arm_q, arm_d;
  logic              test_q, test_d;
  logic              relay_q, relay_d;

  // tick walk: issue index, entry in process, registered read data
  logic [CntW-1:0]   idx_q, idx_d;
  logic              pv_q, pv_d;
  logic [IdxW-1:0]   pidx_q, pidx_d;
  logic [TickW-1:0]  rd_q;
  logic              rd_vld_q;

  // countdown memory, with one valid bit per entry standing for reset to zero
  logic [TickW-1:0]  cnt_mem [ShownPins];
  logic [ShownPins-1:0] vld_q, vld_d;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  logic [TickW-1:0]  mem_wd;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [PinW-1:0]   out_pins_q, out_pins_d;
  logic              out_acc_q, out_acc_d;
  logic              out_arm_q, out_arm_d;
  logic              out_relay_q, out_relay_d;

  logic              out_free;
  logic              accept;
  logic [CntW-1:0]   live;
  logic [PinW-1:0]   live_mask;
  logic [CntW-1:0]   cue_m1;
  logic              cue_live;
  logic              cue_spare;
  logic              acc;
  logic [TickW-1:0]  cur;
  logic [TickW-1:0]  nxt;

  // effective cue count, capped at the pins shown
  assign live = (usable_q > ShownCnt) ? ShownCnt : usable_q;

  always_comb begin
    for (int b = 0; b < PinW; b++) begin
      live_mask[b] = (CntW'(b) < live);
    end
  end

  assign cue_m1    = cue_i - CntW'(1);
  assign cue_live  = (cue_i != '0) && (cue_i <= live);
  assign cue_spare = (cue_i > live) && (cue_i <= ShownCnt);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // shared decrement unit, saturating at zero
  assign cur = rd_vld_q ? rd_q : '0;
  assign nxt = (cur != '0) ? (cur - TickW'(1)) : '0;

  always_comb begin
    state_d     = state_q;
    usable_d    = usable_q;
    on_time_d   = on_time_q;
    pin_d       = pin_q;
    arm_d       = arm_q;
    test_d      = test_q;
    relay_d     = relay_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    vld_d       = vld_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IdxW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_pins_d  = out_pins_q;
    out_acc_d   = out_acc_q;
    out_arm_d   = out_arm_q;
    out_relay_d = out_relay_q;
    acc         = 1'b0;

    // configuration is to be written only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_USABLE_CUES: usable_d  = cfg_data_i[CntW-1:0];
        REG_ON_TIME:     on_time_d = cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_TICK: begin
              idx_d   = '0;
              state_d = ST_TICK;
            end
            CMD_TRIGGER: begin
              if (arm_q && cue_live) begin
                pin_d[cue_m1[IdxW-1:0]] = 1'b1;
                mem_we = 1'b1;
                mem_wa = cue_m1[IdxW-1:0];
                mem_wd = on_time_q;
                vld_d[cue_m1[IdxW-1:0]] = 1'b1;
                acc = 1'b1;
              end
            end
            CMD_SET_SPARE: begin
              if (cue_spare) begin
                pin_d[cue_m1[IdxW-1:0]] = level_i;
                acc = 1'b1;
              end
            end
            CMD_ARM: arm_d = level_i;
            CMD_BEGIN_TEST: begin
              relay_d = 1'b1;
              test_d  = 1'b1;
              arm_d   = 1'b0;
            end
            CMD_TEST: begin
              if (test_q) begin
                if (cue_live) begin
                  pin_d[cue_m1[IdxW-1:0]] = level_i;
                end
                acc = 1'b1;
              end
            end
            CMD_END_TEST: begin
              pin_d   = pin_q & ~live_mask;
              arm_d   = 1'b0;
              test_d  = 1'b0;
              relay_d = 1'b0;
            end
            default: ;
          endcase
          // commands other than tick load the result right away
          if (cmd_e'(cmd_i) != CMD_TICK) begin
            out_valid_d = 1'b1;
            out_pins_d  = pin_d;
            out_acc_d   = acc;
            out_arm_d   = arm_d;
            out_relay_d = relay_d;
          end
        end
      end
      ST_TICK: begin
        // issue the next read
        if (idx_q < live) begin
          rd_en  = 1'b1;
          pv_d   = 1'b1;
          pidx_d = idx_q[IdxW-1:0];
          idx_d  = idx_q + CntW'(1);
        end
        // decrement and write back the entry read last cycle
        if (pv_q) begin
          mem_we        = 1'b1;
          mem_wa        = pidx_q;
          mem_wd        = nxt;
          vld_d[pidx_q] = 1'b1;
          if (nxt == '0) begin
            pin_d[pidx_q] = 1'b0;
          end
        end
        if (!(idx_q < live) && !pv_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pins_d  = pin_q;
          out_acc_d   = 1'b0;
          out_arm_d   = arm_q;
          out_relay_d = relay_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      usable_q    <= UsableReset;
      on_time_q   <= OnTimeReset;
      pin_q       <= '0;
      arm_q       <= 1'b0;
      test_q      <= 1'b0;
      relay_q     <= 1'b0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_pins_q  <= '0;
      out_acc_q   <= 1'b0;
      out_arm_q   <= 1'b0;
      out_relay_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      usable_q    <= usable_d;
      on_time_q   <= on_time_d;
      pin_q       <= pin_d;
      arm_q       <= arm_d;
      test_q      <= test_d;
      relay_q     <= relay_d;
      idx_q       <= idx_d;
      pv_q        <= pv_d;
      pidx_q      <= pidx_d;
      vld_q       <= vld_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      out_valid_q <= out_valid_d;
      out_pins_q  <= out_pins_d;
      out_acc_q   <= out_acc_d;
      out_arm_q   <= out_arm_d;
      out_relay_q <= out_relay_d;
    end
  end

  // countdown memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= cnt_mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pin_levels_o    = out_pins_q;
  assign accepted_o      = out_acc_q;
  assign armed_o         = out_arm_q;
  assign test_relay_on_o = out_relay_q;

endmodule
